/* design/mrdp_pkg.sv */
// Shared constants and lane control type for the multi-row dot product block.
`default_nettype none

package mrdp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxRowsDef    = 8;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned AccBitsDef    = 48;

  // Row-count register
  localparam int unsigned CfgW       = 4;
  localparam logic [CfgW-1:0] RowsRst = 4'd8;

  // Per-lane control, driven by the top-level pipeline control
  typedef struct packed {
    logic load;  // stage A captures a new element
    logic fire;  // stage B consumes the held product
    logic last;  // the product in stage B closes the vector
  } mrdp_ctrl_t;

endpackage

`default_nettype wire

/* design/mrdp_lane.sv */
// One row lane: registered Q2.30 product and saturating accumulator.
`default_nettype none

module mrdp_lane #(
  parameter int unsigned SAMPLE_BITS = mrdp_pkg::SampleBitsDef,
  parameter int unsigned ACC_BITS    = mrdp_pkg::AccBitsDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  mrdp_pkg::mrdp_ctrl_t          ctrl_i,
  input  wire                           active_i,
  input  wire  signed [SAMPLE_BITS-1:0] x_i,
  input  wire  signed [SAMPLE_BITS-1:0] y_i,
  output logic signed [ACC_BITS-1:0]    sum_o
);

  localparam int unsigned ProdW = 2 * SAMPLE_BITS;
  localparam int unsigned SumW  = ((ACC_BITS > ProdW) ? ACC_BITS : ProdW) + 1;
  localparam int unsigned TopW  = SumW - ACC_BITS + 1;

  logic signed [ProdW-1:0]    prod_d, prod_q;
  logic                       act_q;
  logic signed [ACC_BITS-1:0] acc_d, acc_q;
  logic signed [SumW-1:0]     sum_full;
  logic [TopW-1:0]            sum_top;
  logic signed [ACC_BITS-1:0] sum_sat;

  assign prod_d = x_i * y_i;

  // Wide add; saturate when the guard bits disagree with the result sign
  assign sum_full = SumW'(acc_q) + SumW'(prod_q);
  assign sum_top  = sum_full[SumW-1:ACC_BITS-1];

  always_comb begin
    if ((&sum_top) || !(|sum_top)) begin
      sum_sat = sum_full[ACC_BITS-1:0];
    end else if (sum_full[SumW-1]) begin
      sum_sat = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.fire) begin
      if (ctrl_i.last) begin
        acc_d = '0;
      end else if (act_q) begin
        acc_d = sum_sat;
      end
    end
  end

  // Unused rows report zero
  assign sum_o = act_q ? sum_sat : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
      if (ctrl_i.load) begin
        act_q <= active_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

/* design/mrdp_merge.sv */
// Merge stage: collects all lane sums into one result, output register plus skid.
`default_nettype none

module mrdp_merge #(
  parameter int unsigned MAX_ROWS = mrdp_pkg::MaxRowsDef,
  parameter int unsigned ACC_BITS = mrdp_pkg::AccBitsDef
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 push_i,
  input  wire  [MAX_ROWS-1:0][ACC_BITS-1:0]   sums_i,
  output logic                                ready_o,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [((MAX_ROWS*ACC_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned DataW = MAX_ROWS * ACC_BITS;
  localparam int unsigned OutW  = ((DataW + 7) / 8) * 8;

  logic             ov_d, ov_q;
  logic             sv_d, sv_q;
  logic [DataW-1:0] od_q, sd_q;
  logic             main_free;
  logic             load_main, load_skid, main_from_skid;

  assign main_free = !ov_q || m_axis_tready;
  assign ready_o   = !sv_q;

  always_comb begin
    ov_d           = ov_q;
    sv_d           = sv_q;
    load_main      = 1'b0;
    load_skid      = 1'b0;
    main_from_skid = 1'b0;
    if (main_free) begin
      if (sv_q) begin
        ov_d           = 1'b1;
        load_main      = 1'b1;
        main_from_skid = 1'b1;
        load_skid      = push_i;
        sv_d           = push_i;
      end else begin
        ov_d      = push_i;
        load_main = push_i;
      end
    end else if (push_i) begin
      load_skid = 1'b1;
      sv_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main) begin
      od_q <= main_from_skid ? sd_q : sums_i;
    end
    if (load_skid) begin
      sd_q <= sums_i;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OutW'(od_q);

endmodule

`default_nettype wire

/* design/multi_row_dot_product.sv */
// Top level: dot products of one shared vector with up to MAX_ROWS rows.
//
// Usage:
//   Slave stream (s_axis_*): one transfer per vector index. tdata carries the
//   shared element x and the matching element of each row, tlast marks the
//   final index of the vectors.
//   Master stream (m_axis_*): one transfer per vector, issued after the
//   tlast input; tdata carries every row sum, saturated to ACC_BITS.
//   cfg_we_i/cfg_wdata_i write the row count (0 acts as 1, above MAX_ROWS
//   acts as MAX_ROWS); rows at or above the count report zero. Write it only
//   while no vector is in flight.
// Throughput: one input transfer per cycle unless the output buffer is full,
//   set by one multiplier and one accumulator per row lane working in parallel.
// Result path: a tlast input is held in the product register, then its sum is
//   accumulated into the output register (or the skid); a full skid holds it
//   in the product register until the merge stage has room.
// Reset: accumulators clear, row count returns to 8, no result pending.
// Stall: a two-entry output (register plus skid) keeps accepting input while
//   a result waits; only when both hold results does a tlast element stall
//   in the product stage and back-pressure the slave side.
`default_nettype none

module multi_row_dot_product #(
  parameter int unsigned MAX_ROWS    = mrdp_pkg::MaxRowsDef,
  parameter int unsigned SAMPLE_BITS = mrdp_pkg::SampleBitsDef,
  parameter int unsigned ACC_BITS    = mrdp_pkg::AccBitsDef
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  // row count register
  input  wire                                        cfg_we_i,
  input  wire  [mrdp_pkg::CfgW-1:0]                  cfg_wdata_i,
  // slave stream
  input  wire                                        s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata, low bits up: x_value, y_row0 .. y_row(MAX_ROWS-1), zero pad
  input  wire  [(((MAX_ROWS+1)*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire                                        s_axis_tlast,  // last_element
  // master stream
  output logic                                       m_axis_tvalid,
  input  wire                                        m_axis_tready,
  // tdata, low bits up: sum_row0 .. sum_row(MAX_ROWS-1), zero pad
  output logic [((MAX_ROWS*ACC_BITS+7)/8)*8-1:0]     m_axis_tdata
);

  // Row count register
  logic [mrdp_pkg::CfgW-1:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= mrdp_pkg::RowsRst;
    end else if (cfg_we_i) begin
      rows_q <= cfg_wdata_i;
    end
  end

  // Two-stage pipeline control: stage A holds products, stage B accumulates
  logic                 valid_a_q, valid_a_d;
  logic                 last_a_q;
  logic                 merge_ready;
  logic                 a_load;
  logic                 b_fire;
  logic                 push;
  mrdp_pkg::mrdp_ctrl_t ctrl;

  // A tlast product may only leave stage A when the merge stage has room
  assign b_fire        = valid_a_q && (!last_a_q || merge_ready);
  assign s_axis_tready = !valid_a_q || b_fire;
  assign a_load        = s_axis_tvalid && s_axis_tready;
  assign push          = b_fire && last_a_q;

  assign ctrl.load = a_load;
  assign ctrl.fire = b_fire;
  assign ctrl.last = last_a_q;

  always_comb begin
    valid_a_d = valid_a_q;
    if (a_load) begin
      valid_a_d = 1'b1;
    end else if (b_fire) begin
      valid_a_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= valid_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      last_a_q <= s_axis_tlast;
    end
  end

  // Row lanes
  logic signed [SAMPLE_BITS-1:0]       x_value;
  logic [MAX_ROWS-1:0][ACC_BITS-1:0]   lane_sums;

  assign x_value = s_axis_tdata[SAMPLE_BITS-1:0];

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_lane
    logic signed [SAMPLE_BITS-1:0] y_row;
    logic                          row_active;
    logic signed [ACC_BITS-1:0]    row_sum;

    assign y_row = s_axis_tdata[(r+1)*SAMPLE_BITS +: SAMPLE_BITS];
    // Row 0 always runs; a count above MAX_ROWS enables every lane
    assign row_active = (r == 0) || (rows_q > mrdp_pkg::CfgW'(r));

    mrdp_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .active_i (row_active),
      .x_i      (x_value),
      .y_i      (y_row),
      .sum_o    (row_sum)
    );

    assign lane_sums[r] = row_sum;
  end

  // Result merge and output buffering
  mrdp_merge #(
    .MAX_ROWS (MAX_ROWS),
    .ACC_BITS (ACC_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .sums_i        (lane_sums),
    .ready_o       (merge_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A closing product always lands in the output register or the skid
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> m_axis_tvalid)
    else $error("result transfer lost after vector end");

  // The skid only fills while the output register holds a result
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !merge_ready |-> m_axis_tvalid)
    else $error("skid holds a result with the output register empty");

  // Stage A never stalls on an element that does not close a vector
  a_no_mid_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_a_q && !last_a_q) |-> s_axis_tready)
    else $error("input stalled on a non-final element");

endmodule

`default_nettype wire
